// File: src/mlq_pkg.sv
// ----------------------------------------------------------------------------
// mlq_pkg
// Shared codes for the multiple linear queue block: operation kinds,
// result status codes and the configuration reset value.
// ----------------------------------------------------------------------------
package mlq_pkg;

	typedef logic [1:0] status_t;
	typedef logic       kind_t;

	localparam kind_t KIND_ENQ = 1'b0;
	localparam kind_t KIND_DEQ = 1'b1;

	localparam status_t ST_DONE    = 2'd0;
	localparam status_t ST_FULL    = 2'd1;
	localparam status_t ST_EMPTY   = 2'd2;
	localparam status_t ST_INVALID = 2'd3;

	localparam logic [3:0] CFG_QUEUES_RESET = 4'd8;

endpackage

// File: src/mlq_ram.sv
// ----------------------------------------------------------------------------
// mlq_ram
// Generic single-clock RAM: one write port, one read port with read enable,
// read data registered and held while the read enable is low.
// ----------------------------------------------------------------------------
module mlq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/multi_linear_queue.sv
// ----------------------------------------------------------------------------
// multi_linear_queue
// Several linear queues sharing one slot memory, each owning a fixed slice.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one operation per beat: kind
//   (0 enqueue, 1 dequeue), queue_index and item_in. Output channel
//   (out_valid/out_stall) returns one beat per operation: status and
//   item_out (dequeued value, else 0). The user must write queues_in_use
//   via cfg_we/cfg_wdata only while idle; the block does not enforce this.
//   Queue numbers at or above it, or at or above QUEUE_COUNT, report invalid.
// Sequencing:
//   One operation is in flight at a time. An enqueue or a rejected
//   operation reads the pointer memory, then does its update; a
//   successful dequeue reads the pointer memory, then the slot memory.
//   The next beat is taken as soon as the result is in the output register,
//   even if that result has not been taken yet.
// Reset:
//   arst_n clears all queues to empty and sets queues_in_use to 8. The slot
//   and pointer memories are not cleared; per-queue occupied flags cover it.
// Stall:
//   While out_stall holds a result, a following operation waits before its
//   update step, so no state changes until its result can be registered.
// ----------------------------------------------------------------------------
module multi_linear_queue
	import mlq_pkg::*;
#(
	parameter int QUEUE_COUNT = 8,
	parameter int QUEUE_DEPTH = 16,
	parameter int ITEM_WIDTH  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [3:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [2:0]         queue_index,
	input  logic signed [31:0] item_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] item_out
);

	localparam int QW   = QUEUE_COUNT > 1 ? $clog2(QUEUE_COUNT) : 1;
	localparam int PW   = $clog2(QUEUE_DEPTH);
	localparam int SLOTS = QUEUE_COUNT * QUEUE_DEPTH;
	localparam int AW   = $clog2(SLOTS);
	localparam logic [PW-1:0] LAST_POS = PW'(QUEUE_DEPTH - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_PTR  = 2'd1;
	localparam logic [1:0] S_SLOT = 2'd2;

	logic [1:0]             state_q;
	logic [3:0]             queues_in_use_q;
	logic [QUEUE_COUNT-1:0] occ_q;

	kind_t                  kind_q;
	logic [2:0]             qnum_q;
	logic [ITEM_WIDTH-1:0]  item_q;

	logic                   out_valid_q;
	status_t                status_q;
	logic [31:0]            item_out_q;

	logic                   in_take;
	logic                   out_free;
	logic [QW-1:0]          qi;
	logic                   q_ok;
	logic                   occ_cur;
	logic [PW-1:0]          head_rd;
	logic [PW-1:0]          tail_rd;
	logic [2*PW-1:0]        ptr_rdata;
	logic                   ptr_we;
	logic [2*PW-1:0]        ptr_wdata;
	logic [AW-1:0]          base;
	logic                   slot_we;
	logic                   slot_re;
	logic [AW-1:0]          slot_addr;
	logic [ITEM_WIDTH-1:0]  slot_rdata;
	logic                   occ_set;
	logic                   occ_clr;
	logic                   ptr_done;
	status_t                ptr_status;
	logic                   deq_go;
	logic                   res_load;

	assign in_take  = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign res_load = (ptr_done && !deq_go) || (state_q == S_SLOT && out_free);

	assign qi      = QW'(qnum_q);
	assign q_ok    = (4'(qnum_q) < queues_in_use_q) && (32'(qnum_q) < QUEUE_COUNT);
	assign occ_cur = occ_q[qi];
	assign head_rd = ptr_rdata[2*PW-1:PW];
	assign tail_rd = ptr_rdata[PW-1:0];
	assign base    = AW'(qi) * AW'(QUEUE_DEPTH);

	// update step decisions, made in S_PTR once the pointer word is back
	always_comb begin
		ptr_status = ST_DONE;
		ptr_we     = 1'b0;
		ptr_wdata  = '0;
		slot_we    = 1'b0;
		slot_re    = 1'b0;
		slot_addr  = base;
		occ_set    = 1'b0;
		occ_clr    = 1'b0;
		deq_go     = 1'b0;
		ptr_done   = (state_q == S_PTR) && out_free;
		if (!q_ok) begin
			ptr_status = ST_INVALID;
		end else if (kind_q == KIND_ENQ) begin
			if (occ_cur && tail_rd == LAST_POS) begin
				ptr_status = ST_FULL;
			end else if (!occ_cur) begin
				ptr_we    = ptr_done;
				ptr_wdata = '0;
				slot_we   = ptr_done;
				slot_addr = base;
				occ_set   = ptr_done;
			end else begin
				ptr_we    = ptr_done;
				ptr_wdata = {head_rd, tail_rd + PW'(1)};
				slot_we   = ptr_done;
				slot_addr = base + AW'(tail_rd + PW'(1));
			end
		end else begin
			if (!occ_cur) begin
				ptr_status = ST_EMPTY;
			end else begin
				deq_go    = 1'b1;
				slot_re   = ptr_done;
				slot_addr = base + AW'(head_rd);
				ptr_we    = ptr_done;
				// last item drains the queue back to the empty mark
				if (head_rd == tail_rd) begin
					ptr_wdata = '0;
					occ_clr   = ptr_done;
				end else begin
					ptr_wdata = {head_rd + PW'(1), tail_rd};
				end
			end
		end
	end

	mlq_ram #(
		.WIDTH (2 * PW),
		.DEPTH (QUEUE_COUNT)
	) u_ptr_ram (
		.clk   (clk),
		.we    (ptr_we),
		.waddr (qi),
		.wdata (ptr_wdata),
		.re    (in_take),
		.raddr (QW'(queue_index)),
		.rdata (ptr_rdata)
	);

	mlq_ram #(
		.WIDTH (ITEM_WIDTH),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_addr),
		.wdata (item_q),
		.re    (slot_re),
		.raddr (slot_addr),
		.rdata (slot_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			queues_in_use_q <= CFG_QUEUES_RESET;
			occ_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				queues_in_use_q <= cfg_wdata;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (occ_set) begin
				occ_q[qi] <= 1'b1;
			end
			if (occ_clr) begin
				occ_q[qi] <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_PTR;
					end
				end
				S_PTR: begin
					if (ptr_done) begin
						if (deq_go) begin
							state_q <= S_SLOT;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SLOT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_q <= kind;
			qnum_q <= queue_index;
			item_q <= ITEM_WIDTH'($unsigned(item_in));
		end
		if (ptr_done && !deq_go) begin
			status_q   <= ptr_status;
			item_out_q <= '0;
		end
		if (state_q == S_SLOT && out_free) begin
			status_q   <= ST_DONE;
			item_out_q <= 32'($signed(slot_rdata));
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign item_out  = item_out_q;

`ifndef SYNTHESIS
	a_slot_from_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SLOT |-> $past(state_q) == S_PTR || $past(state_q) == S_SLOT)
		else $error("slot wait entered without pointer step");

	a_take_to_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_PTR)
		else $error("accepted beat did not start pointer step");

	a_slot_we_enq: assert property (@(posedge clk) disable iff (!arst_n)
		slot_we |-> state_q == S_PTR && kind_q == KIND_ENQ && q_ok && out_free)
		else $error("slot write outside a valid enqueue");

	a_one_slot_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(slot_we && slot_re))
		else $error("slot read and write in the same cycle");

	a_zero_unless_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> status_q == ST_DONE || item_out_q == 32'd0)
		else $error("nonzero item with a failing status");
`endif

endmodule
